// ----- rtl/cptb_pkg.sv -----
// Shared types, constants and helpers for the cascaded prescaled timer bank.
// Used by cptb_cell, the top level and the checker; no dependencies.
`default_nettype none
package cptb_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int PC_WIDTH    = 11;
    localparam int DATA_WIDTH  = 16;
    localparam int CYC_WIDTH   = 8;
    localparam int SEL_WIDTH   = 2;
    localparam int ACT_WIDTH   = 3;
    localparam int IRQ_WIDTH   = 4;

    localparam int S_TDATA_WIDTH = 32;
    localparam int M_TDATA_WIDTH = 24;

    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_ENABLE_BIT  = 7;

    typedef enum logic [ACT_WIDTH-1:0] {
        ACT_TICK      = 3'd0,
        ACT_WR_CTL    = 3'd1,
        ACT_WR_RELOAD = 3'd2,
        ACT_RD_COUNT  = 3'd3,
        ACT_RD_CTL    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic                  run;
        logic                  wr_ctl;
        logic                  wr_reload;
        logic [DATA_WIDTH-1:0] data;
        logic [CYC_WIDTH-1:0]  cycles;
    } t_cell_cmd;

    typedef struct packed {
        logic pending;
        logic irq;
    } t_cell_stat;

    function automatic logic [PC_WIDTH-1:0] prescale(input logic [1:0] code);
        logic [PC_WIDTH-1:0] p;
        case (code)
            2'd0:    p = PC_WIDTH'(1);
            2'd1:    p = PC_WIDTH'(64);
            2'd2:    p = PC_WIDTH'(256);
            default: p = PC_WIDTH'(1024);
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cptb_cell.sv -----
// One timer cell: counter, reload, control word and prescale accumulator.
// Takes its overflow carry from the previous cell; depends on cptb_pkg.
`default_nettype none
module cptb_cell
    import cptb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_cmd              i_cmd,
    input  wire logic                   i_sel,
    input  wire logic                   i_first,
    input  wire logic                   i_carry,
    output      logic                   o_carry,
    output      logic [COUNT_WIDTH-1:0] o_count,
    output      logic [DATA_WIDTH-1:0]  o_ctl,
    output      t_cell_stat             o_stat
);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic [DATA_WIDTH-1:0]  r_ctl, n_ctl;
    logic [PC_WIDTH-1:0]    r_acc, n_acc;

    logic [PC_WIDTH-1:0] pre;
    logic                enabled;
    logic                active;
    logic                cascaded;
    logic                pending;
    logic                inc;
    logic                ovf;

    always_comb begin
        pre      = prescale(r_ctl[1:0]);
        enabled  = r_ctl[CTL_ENABLE_BIT];
        active   = enabled && (!r_ctl[CTL_CASCADE_BIT] || i_first);
        cascaded = enabled && r_ctl[CTL_CASCADE_BIT] && !i_first;
        pending  = active && (r_acc >= pre);
        inc      = i_cmd.run && (pending || (cascaded && i_carry));
        ovf      = inc && (&r_count);
    end

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_ctl    = r_ctl;
        n_acc    = r_acc;
        if (ovf) begin
            n_count = r_reload;
        end else if (inc) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
        if (i_cmd.start && active) begin
            n_acc = r_acc + PC_WIDTH'(i_cmd.cycles);
        end else if (i_cmd.run && pending) begin
            n_acc = r_acc - pre;
        end
        if (i_cmd.wr_ctl && i_sel) begin
            n_ctl = i_cmd.data;
            if (i_cmd.data[CTL_ENABLE_BIT] && !enabled) begin
                n_count = r_reload;
                n_acc   = '0;
            end
        end
        if (i_cmd.wr_reload && i_sel) begin
            n_reload = COUNT_WIDTH'(i_cmd.data);
            if (!enabled) begin
                n_count = COUNT_WIDTH'(i_cmd.data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_ctl    <= '0;
            r_acc    <= '0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_ctl    <= n_ctl;
            r_acc    <= n_acc;
        end
    end

    assign o_carry        = ovf;
    assign o_count        = r_count;
    assign o_ctl          = r_ctl;
    assign o_stat.pending = pending;
    assign o_stat.irq     = ovf && r_ctl[CTL_IRQ_BIT];

endmodule
`default_nettype wire

// ----- rtl/cascaded_prescaled_timer_bank_unit.sv -----
// Register accesses pass from acceptance through the done state into the output register;
// a tick passes through the run state until no timer has prescaler counts left to drain,
// one machine cycle per clock through the cell row, then through the done state.
// Throughput: one beat at a time; the next beat is taken once the result moves to the
// output register. Reset (synchronous, active low) clears all timer state to zero.
// Depends on cptb_pkg and cptb_cell.
`default_nettype none
module cascaded_prescaled_timer_bank_unit
    import cptb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output      logic                     s_axis_tready,
    // [2:0] action, [4:3] timer_select, [20:5] write_data, [28:21] tick_cycles
    input  wire logic [S_TDATA_WIDTH-1:0] s_axis_tdata,
    output      logic                     m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [15:0] read_data, [19:16] irq_mask
    output      logic [M_TDATA_WIDTH-1:0] m_axis_tdata
);

    t_state r_state, n_state;

    logic                  r_ovalid, n_ovalid;
    logic [DATA_WIDTH-1:0] r_odata_rd, n_odata_rd;
    logic [IRQ_WIDTH-1:0]  r_odata_irq, n_odata_irq;
    logic [DATA_WIDTH-1:0] r_res_rd, n_res_rd;
    logic [NUM_TIMERS-1:0] r_res_irq, n_res_irq;

    t_action               act;
    logic [SEL_WIDTH-1:0]  sel;
    logic                  accept;
    t_cell_cmd             cmd;
    logic [NUM_TIMERS:0]   carry;
    logic [NUM_TIMERS-1:0] cell_sel;
    logic [NUM_TIMERS-1:0] pend_vec;
    logic [NUM_TIMERS-1:0] irq_vec;
    logic [DATA_WIDTH-1:0] rd_count;
    logic [DATA_WIDTH-1:0] rd_ctl;

    logic       [COUNT_WIDTH-1:0] count_arr [NUM_TIMERS];
    logic       [DATA_WIDTH-1:0]  ctl_arr   [NUM_TIMERS];
    t_cell_stat                   stat_arr  [NUM_TIMERS];

    assign act           = t_action'(s_axis_tdata[2:0]);
    assign sel           = s_axis_tdata[4:3];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        cmd.start     = accept && (act == ACT_TICK);
        cmd.run       = (r_state == ST_RUN);
        cmd.wr_ctl    = accept && (act == ACT_WR_CTL);
        cmd.wr_reload = accept && (act == ACT_WR_RELOAD);
        cmd.data      = s_axis_tdata[20:5];
        cmd.cycles    = s_axis_tdata[28:21];
    end

    assign carry[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
            assign cell_sel[gi] = (int'(sel) == gi);
            cptb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_sel   (cell_sel[gi]),
                .i_first (gi == 0),
                .i_carry (carry[gi]),
                .o_carry (carry[gi+1]),
                .o_count (count_arr[gi]),
                .o_ctl   (ctl_arr[gi]),
                .o_stat  (stat_arr[gi])
            );
            assign pend_vec[gi] = stat_arr[gi].pending;
            assign irq_vec[gi]  = stat_arr[gi].irq;
        end
    endgenerate

    always_comb begin
        rd_count = '0;
        rd_ctl   = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (cell_sel[i]) begin
                rd_count = DATA_WIDTH'(count_arr[i]);
                rd_ctl   = ctl_arr[i];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_odata_rd  = r_odata_rd;
        n_odata_irq = r_odata_irq;
        n_res_rd    = r_res_rd;
        n_res_irq   = r_res_irq;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_irq = '0;
                    case (act)
                        ACT_RD_COUNT: n_res_rd = rd_count;
                        ACT_RD_CTL:   n_res_rd = rd_ctl;
                        default:      n_res_rd = '0;
                    endcase
                    n_state = (act == ACT_TICK) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                n_res_irq = r_res_irq | irq_vec;
                if (!(|pend_vec)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid    = 1'b1;
                    n_odata_rd  = r_res_rd;
                    n_odata_irq = IRQ_WIDTH'(r_res_irq);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata_rd  <= n_odata_rd;
        r_odata_irq <= n_odata_irq;
        r_res_rd    <= n_res_rd;
        r_res_irq   <= n_res_irq;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(M_TDATA_WIDTH - DATA_WIDTH - IRQ_WIDTH){1'b0}},
                            r_odata_irq, r_odata_rd};

endmodule
`default_nettype wire

// ----- rtl/cptb_checker.sv -----
// Port-level checker for the timer bank, bound to the top level.
// Depends on cptb_pkg and cascaded_prescaled_timer_bank_unit.
`default_nettype none
module cptb_checker
    import cptb_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic [S_TDATA_WIDTH-1:0] s_axis_tdata,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [M_TDATA_WIDTH-1:0] m_axis_tdata
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_open;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_no_extra_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_open != 2'd0)
        else $error("output beat without an open input beat");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open != 2'd3)
        else $error("more than two beats in flight");

    a_irq_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[19:16] != 4'd0) |-> m_axis_tdata[15:0] == 16'd0)
        else $error("interrupt mask on a read result");

endmodule

bind cascaded_prescaled_timer_bank_unit cptb_checker u_cptb_checker (.*);
`default_nettype wire
